FILE: sv/pcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcd_pkg;

    // Field and register widths fixed by the interface.
    localparam int COEFF_W      = 16;
    localparam int COEFF_IDX_W  = 7;
    localparam int THR_W        = 37;
    localparam int PLEN_W       = 8;
    localparam int PBITS_W      = 12;
    localparam int SPB_W        = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 37;
    localparam int COUNT_W      = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_LEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PACKET_BITS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BIT = 2'd3;

    // Register reset values.
    localparam logic [THR_W-1:0]   THRESHOLD_RST       = 37'd3221225472;
    localparam logic [PLEN_W-1:0]  PREAMBLE_LEN_RST    = 8'd128;
    localparam logic [PBITS_W-1:0] PACKET_BITS_RST     = 12'd500;
    localparam logic [SPB_W-1:0]   SAMPLES_PER_BIT_RST = 4'd2;

    // Input word function codes.
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MAC   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    typedef struct packed {
        logic start;
        logic issue;
    } mac_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/pcd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pcd_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: sv/pcd_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module pcd_mac #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int MAX_TAPS     = 128,
    localparam int ACC_W       = SAMPLE_WIDTH + 16 + $clog2(MAX_TAPS)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire pcd_pkg::mac_ctrl_t             ctrl,
    input  wire logic signed [SAMPLE_WIDTH-1:0] win_data,
    input  wire logic signed [15:0]             tap_data,
    output logic                                busy,
    output logic signed [ACC_W-1:0]             acc
);

    import pcd_pkg::*;

    localparam int PROD_W = SAMPLE_WIDTH + COEFF_W;

    logic                     data_valid_reg;
    logic                     prod_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // Read data arrives in the cycle after the address is issued.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            data_valid_reg <= ctrl.issue;
            prod_valid_reg <= data_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_valid_reg)
        begin
            prod_reg <= win_data * tap_data;
        end
        if (ctrl.start)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign busy = data_valid_reg | prod_valid_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

FILE: sv/preamble_correlator_demodulator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake          Word
// in       in   in_valid/in_stall  func, coeff_index, coeff_value, sample
// out      out  out_valid/out_stall data_bit, last_bit
// cfg      in   cfg_wr_en          cfg_index, cfg_data
//
// A coefficient load or a sample while receiving a packet is handled in the idle state.
// A hunting sample with a full window runs one multiply-accumulate per tap through
// the shared multiplier, fed by the window and tap memories, then drains the read
// and product stages; input words are stalled until it is done.
// Reset leaves the block hunting with an empty window and default registers.
// While a result word waits under out_stall, packet-mode input words are stalled.

module preamble_correlator_demodulator #(
    parameter int MAX_TAPS     = 128,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                func,
    input  wire logic [pcd_pkg::COEFF_IDX_W-1:0]     coeff_index,
    input  wire logic signed [pcd_pkg::COEFF_W-1:0]  coeff_value,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      sample,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     data_bit,
    output logic                                     last_bit,
    input  wire logic                                cfg_wr_en,
    input  wire logic [pcd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [pcd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import pcd_pkg::*;

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int LW    = $clog2(MAX_TAPS + 1);
    localparam int CNT_W = (LW > PLEN_W) ? LW : PLEN_W;
    localparam int ACC_W = SAMPLE_WIDTH + 16 + $clog2(MAX_TAPS);
    localparam int CMP_W = (ACC_W > THR_W + 1) ? ACC_W : THR_W + 1;
    localparam int BA_W  = SAMPLE_WIDTH + SPB_W;

    // Configuration registers.
    logic [THR_W-1:0]   threshold_reg;
    logic [PLEN_W-1:0]  preamble_len_reg;
    logic [PBITS_W-1:0] packet_bits_reg;
    logic [SPB_W-1:0]   spb_reg;

    // Sequencer and block state.
    state_t                  state_reg, state_next;
    logic                    receiving_reg, receiving_next;
    logic [LW-1:0]           fill_reg, fill_next;
    logic [AW-1:0]           wp_reg, wp_next;
    logic [AW-1:0]           rd_addr_reg, rd_addr_next;
    logic [AW-1:0]           j_reg, j_next;
    logic [CNT_W-1:0]        len_reg, len_next;
    logic [COUNT_W-1:0]      sample_count_reg, sample_count_next;
    logic [COUNT_W-1:0]      last_detect_reg, last_detect_next;
    logic signed [BA_W-1:0]  bit_accum_reg, bit_accum_next;
    logic [SPB_W-1:0]        chip_count_reg, chip_count_next;
    logic [PBITS_W-1:0]      bit_count_reg, bit_count_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    data_bit_reg, data_bit_next;
    logic                    last_bit_reg, last_bit_next;

    // Datapath helpers.
    logic                    accept;
    logic                    win_we;
    logic                    tap_we;
    mac_ctrl_t               mac_ctrl;
    logic                    mac_busy;
    logic signed [ACC_W-1:0] mac_acc;
    logic [SAMPLE_WIDTH-1:0] win_rd_data;
    logic [COEFF_W-1:0]      tap_rd_data;
    logic [CNT_W-1:0]        eff_len;
    logic [AW-1:0]           len_m1;
    logic [AW-1:0]           wp_inc;
    logic [AW-1:0]           start_addr;
    logic [LW-1:0]           fill_inc;
    logic [COUNT_W-1:0]      sample_count_inc;
    logic signed [BA_W-1:0]  accum_sum;
    logic [SPB_W-1:0]        chip_inc;
    logic [SPB_W-1:0]        spb_eff;
    logic [PBITS_W-1:0]      pb_eff;
    logic [PBITS_W-1:0]      bit_count_inc;
    logic signed [CMP_W-1:0] corr_ext;
    logic signed [CMP_W-1:0] thr_ext;
    logic                    detect;

    assign accept   = in_valid & ~in_stall;
    assign in_stall = (state_reg != ST_IDLE) | (receiving_reg & out_valid_reg & out_stall);

    assign eff_len = (32'(preamble_len_reg) > 32'(MAX_TAPS)) ? CNT_W'(MAX_TAPS)
                                                              : CNT_W'(preamble_len_reg);
    assign len_m1  = AW'(eff_len - 1'b1);
    assign wp_inc  = (wp_reg == AW'(MAX_TAPS - 1)) ? '0 : wp_reg + 1'b1;

    // The oldest sample of the window sits len-1 entries behind the newest.
    assign start_addr = (wp_inc >= len_m1) ? wp_inc - len_m1
                      : AW'(32'(wp_inc) + 32'(MAX_TAPS) - 32'(len_m1));

    assign fill_inc         = (fill_reg == LW'(MAX_TAPS)) ? fill_reg : fill_reg + 1'b1;
    assign sample_count_inc = (sample_count_reg == '1) ? sample_count_reg
                                                       : sample_count_reg + 1'b1;

    assign accum_sum     = bit_accum_reg + BA_W'(sample);
    assign chip_inc      = chip_count_reg + 1'b1;
    assign spb_eff       = (spb_reg == '0) ? SPB_W'(1) : spb_reg;
    assign pb_eff        = (packet_bits_reg == '0) ? PBITS_W'(1) : packet_bits_reg;
    assign bit_count_inc = bit_count_reg + 1'b1;

    assign corr_ext = CMP_W'(mac_acc);
    assign thr_ext  = $signed(CMP_W'(threshold_reg));
    assign detect   = (corr_ext > thr_ext) &&
                      ((sample_count_reg - last_detect_reg) > COUNT_W'(len_reg));

    always_comb
    begin
        state_next        = state_reg;
        receiving_next    = receiving_reg;
        fill_next         = fill_reg;
        wp_next           = wp_reg;
        rd_addr_next      = rd_addr_reg;
        j_next            = j_reg;
        len_next          = len_reg;
        sample_count_next = sample_count_reg;
        last_detect_next  = last_detect_reg;
        bit_accum_next    = bit_accum_reg;
        chip_count_next   = chip_count_reg;
        bit_count_next    = bit_count_reg;
        out_valid_next    = out_valid_reg & out_stall;
        data_bit_next     = data_bit_reg;
        last_bit_next     = last_bit_reg;
        win_we            = 1'b0;
        tap_we            = 1'b0;
        mac_ctrl          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_LOAD)
                    begin
                        tap_we = ({25'd0, coeff_index} < 32'(MAX_TAPS));
                    end
                    else if (!receiving_reg)
                    begin
                        win_we    = 1'b1;
                        wp_next   = wp_inc;
                        fill_next = fill_inc;
                        if ((eff_len != '0) && (CNT_W'(fill_inc) >= eff_len))
                        begin
                            len_next     = eff_len;
                            rd_addr_next = start_addr;
                            j_next       = '0;
                            mac_ctrl.start = 1'b1;
                            state_next   = ST_MAC;
                        end
                        else
                        begin
                            sample_count_next = sample_count_inc;
                        end
                    end
                    else
                    begin
                        sample_count_next = sample_count_inc;
                        if (chip_inc >= spb_eff)
                        begin
                            out_valid_next  = 1'b1;
                            data_bit_next   = !(accum_sum > 0);
                            last_bit_next   = (bit_count_inc >= pb_eff);
                            bit_accum_next  = '0;
                            chip_count_next = '0;
                            if (bit_count_inc >= pb_eff)
                            begin
                                receiving_next = 1'b0;
                                fill_next      = '0;
                                bit_count_next = '0;
                            end
                            else
                            begin
                                bit_count_next = bit_count_inc;
                            end
                        end
                        else
                        begin
                            bit_accum_next  = accum_sum;
                            chip_count_next = chip_inc;
                        end
                    end
                end
            end

            ST_MAC:
            begin
                mac_ctrl.issue = 1'b1;
                if (j_reg == AW'(len_reg - 1'b1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    j_next       = j_reg + 1'b1;
                    rd_addr_next = (rd_addr_reg == AW'(MAX_TAPS - 1)) ? '0
                                                                       : rd_addr_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    if (detect)
                    begin
                        last_detect_next = sample_count_reg;
                        fill_next        = '0;
                        receiving_next   = 1'b1;
                        bit_accum_next   = '0;
                        chip_count_next  = '0;
                        bit_count_next   = '0;
                    end
                    sample_count_next = sample_count_inc;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            receiving_reg    <= 1'b0;
            fill_reg         <= '0;
            wp_reg           <= '0;
            rd_addr_reg      <= '0;
            j_reg            <= '0;
            len_reg          <= '0;
            sample_count_reg <= '0;
            last_detect_reg  <= '0;
            bit_accum_reg    <= '0;
            chip_count_reg   <= '0;
            bit_count_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            receiving_reg    <= receiving_next;
            fill_reg         <= fill_next;
            wp_reg           <= wp_next;
            rd_addr_reg      <= rd_addr_next;
            j_reg            <= j_next;
            len_reg          <= len_next;
            sample_count_reg <= sample_count_next;
            last_detect_reg  <= last_detect_next;
            bit_accum_reg    <= bit_accum_next;
            chip_count_reg   <= chip_count_next;
            bit_count_reg    <= bit_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_bit_reg <= data_bit_next;
        last_bit_reg <= last_bit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RST;
            preamble_len_reg <= PREAMBLE_LEN_RST;
            packet_bits_reg  <= PACKET_BITS_RST;
            spb_reg          <= SAMPLES_PER_BIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_THRESHOLD:       threshold_reg    <= cfg_data[THR_W-1:0];
                REG_PREAMBLE_LEN:    preamble_len_reg <= cfg_data[PLEN_W-1:0];
                REG_PACKET_BITS:     packet_bits_reg  <= cfg_data[PBITS_W-1:0];
                REG_SAMPLES_PER_BIT: spb_reg          <= cfg_data[SPB_W-1:0];
                default:             threshold_reg    <= threshold_reg;
            endcase
        end
    end

    pcd_ram #(
        .DEPTH (MAX_TAPS),
        .WIDTH (SAMPLE_WIDTH)
    ) u_window (
        .clk     (clk),
        .wr_en   (win_we),
        .wr_addr (wp_inc),
        .wr_data (sample),
        .rd_addr (rd_addr_reg),
        .rd_data (win_rd_data)
    );

    pcd_ram #(
        .DEPTH (MAX_TAPS),
        .WIDTH (COEFF_W)
    ) u_taps (
        .clk     (clk),
        .wr_en   (tap_we),
        .wr_addr (AW'(coeff_index)),
        .wr_data (coeff_value),
        .rd_addr (j_reg),
        .rd_data (tap_rd_data)
    );

    pcd_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_TAPS     (MAX_TAPS)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mac_ctrl),
        .win_data ($signed(win_rd_data)),
        .tap_data ($signed(tap_rd_data)),
        .busy     (mac_busy),
        .acc      (mac_acc)
    );

    assign out_valid = out_valid_reg;
    assign data_bit  = data_bit_reg;
    assign last_bit  = last_bit_reg;

endmodule

`default_nettype wire

FILE: sv/pcd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pcd_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic func,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic data_bit,
    input wire logic last_bit
);

    import pcd_pkg::*;

    // A held result word keeps its bits until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(data_bit) && $stable(last_bit)))
        else $error("result word changed while stalled");

    // A new result word only follows an accepted sample.
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && (func == FUNC_SAMPLE)))
        else $error("result word without an accepted sample");

    // A coefficient load never produces a result.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (func == FUNC_LOAD) && !out_valid) |=> !out_valid)
        else $error("coefficient load produced a result");

    // After a coefficient load the block is ready for the next word, unless a result word is held.
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (func == FUNC_LOAD)) |=> (!in_stall || (out_valid && out_stall)))
        else $error("block busy after a coefficient load");

endmodule

bind preamble_correlator_demodulator pcd_checker u_pcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_bit  (data_bit),
    .last_bit  (last_bit)
);

`default_nettype wire

FILE: tb/sv/preamble_correlator_demodulator_tb.sv
`timescale 1ns / 1ps

import pcd_pkg::*;

localparam int NUM_TAPS = 128;

// Tracks the expected bit words of the correlator and demodulator.
class bit_scoreboard;
    bit [THR_W-1:0]   thr;
    bit [PLEN_W-1:0]  plen;
    bit [PBITS_W-1:0] pbits;
    bit [SPB_W-1:0]   spb;

    bit          receiving;
    int          win[NUM_TAPS];     // win[0] holds the newest sample
    int          taps[NUM_TAPS];
    int          win_fill;
    int unsigned n_samples;
    int unsigned last_hit;
    int          accum;
    int          chips;
    int          bits_done;

    bit [1:0]    bits_due[$];       // {data_bit, last_bit}
    int          errors;
    int          checked;
    int          detections;

    function new();
        thr   = THRESHOLD_RST;
        plen  = PREAMBLE_LEN_RST;
        pbits = PACKET_BITS_RST;
        spb   = SAMPLES_PER_BIT_RST;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_THRESHOLD:    thr   = val[THR_W-1:0];
            REG_PREAMBLE_LEN: plen  = val[PLEN_W-1:0];
            REG_PACKET_BITS:  pbits = val[PBITS_W-1:0];
            default:          spb   = val[SPB_W-1:0];
        endcase
    endfunction

    function int taps_in_use();
        return (plen > NUM_TAPS) ? NUM_TAPS : int'(plen);
    endfunction

    // Correlation that a clean copy of the preamble would reach.
    function longint tap_energy(int n_taps);
        longint e;
        int k;
        e = 0;
        for (k = 0; k < n_taps; k++)
            e += longint'(taps[k]) * longint'(taps[k]);
        return e;
    endfunction

    function void take_word(logic fn, logic [COEFF_IDX_W-1:0] idx,
                            logic signed [COEFF_W-1:0] cval, logic signed [15:0] smp);
        int unsigned len;
        int unsigned since;
        int          spb_e;
        int          pb_e;
        longint      corr;
        int          k;
        if (fn == FUNC_LOAD) begin
            taps[idx] = cval;
            return;
        end
        if (!receiving) begin
            len = taps_in_use();
            for (k = NUM_TAPS - 1; k > 0; k--)
                win[k] = win[k-1];
            win[0] = smp;
            if (win_fill < NUM_TAPS)
                win_fill++;
            if (len > 0 && win_fill >= len) begin
                corr = 0;
                for (k = 0; k < len; k++)
                    corr += longint'(win[len-1-k]) * longint'(taps[k]);
                since = n_samples - last_hit;
                if (corr > longint'(thr) && since > len) begin
                    last_hit  = n_samples;
                    win_fill  = 0;
                    receiving = 1'b1;
                    accum     = 0;
                    chips     = 0;
                    bits_done = 0;
                    detections++;
                end
            end
        end
        else begin
            spb_e = (spb == 0) ? 1 : int'(spb);
            pb_e  = (pbits == 0) ? 1 : int'(pbits);
            accum += smp;
            chips++;
            if (chips >= spb_e) begin
                bits_done++;
                bits_due.push_back({(accum > 0) ? 1'b0 : 1'b1, (bits_done >= pb_e) ? 1'b1 : 1'b0});
                accum = 0;
                chips = 0;
                if (bits_done >= pb_e) begin
                    receiving = 1'b0;
                    win_fill  = 0;
                    bits_done = 0;
                end
            end
        end
        if (n_samples != 32'hFFFF_FFFF)
            n_samples++;
    endfunction

    function void note_error(string msg);
        errors++;
        if (errors <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function void check_bit(logic seen_data, logic seen_last);
        bit [1:0] want;
        checked++;
        if (bits_due.size() == 0) begin
            note_error($sformatf("word data_bit=%0b last_bit=%0b arrived with none expected",
                                 seen_data, seen_last));
            return;
        end
        want = bits_due[0];
        bits_due.delete(0);
        if (want[1] !== seen_data)
            note_error($sformatf("data_bit expected %0b, got %0b (word %0d)",
                                 want[1], seen_data, checked));
        if (want[0] !== seen_last)
            note_error($sformatf("last_bit expected %0b, got %0b (word %0d)",
                                 want[0], seen_last, checked));
    endfunction

    function int waiting();
        return bits_due.size();
    endfunction
endclass

module preamble_correlator_demodulator_tb;

    localparam int ITEMS = 1800;
    localparam int QUIET = 200;
    localparam int LIMIT = 2_000_000;

    localparam logic signed [15:0] DIRECTED_SAMPLES[15] = '{
        16'sh0000, 16'shFFFF, 16'sh7FFF, 16'sh8000, 16'sh0000,
        16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
        16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0001, 16'shFFFF
    };

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic                          func;
    logic [COEFF_IDX_W-1:0]        coeff_index;
    logic signed [COEFF_W-1:0]     coeff_value;
    logic signed [15:0]            sample;
    logic                          out_valid;
    logic                          out_stall;
    logic                          data_bit;
    logic                          last_bit;
    logic                          cfg_wr_en;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;

    bit_scoreboard sb;
    bit            idle_on;
    int            words_sent;
    int            reg_writes;
    int            cycles;

    preamble_correlator_demodulator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .coeff_index (coeff_index),
        .coeff_value (coeff_value),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_bit    (data_bit),
        .last_bit    (last_bit),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles with %0d words outstanding", cycles, sb.waiting());
            $display("status: fail");
            $finish;
        end
    end

    // Result side: sample the handshake at the edge, check after the edge settles.
    always
    begin : result_sink
        bit   got;
        logic seen_data;
        logic seen_last;
        int   hold;
        @(posedge clk);
        got       = rst_n && out_valid && !out_stall;
        seen_data = data_bit;
        seen_last = last_bit;
        if (hold > 0)
            hold--;
        else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            hold = $urandom_range(0, 11);
        end
        else
            out_stall <= 1'b0;
        if (got) begin
            @(negedge clk);
            sb.check_bit(seen_data, seen_last);
        end
    end

    task automatic send_word(logic fn, logic [COEFF_IDX_W-1:0] idx,
                             logic signed [COEFF_W-1:0] cval, logic signed [15:0] smp);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= fn;
        coeff_index <= idx;
        coeff_value <= cval;
        sample      <= smp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_word(fn, idx, cval, smp);
        words_sent++;
    endtask

    task automatic send_sample(logic signed [15:0] smp);
        send_word(FUNC_SAMPLE, COEFF_IDX_W'($urandom), COEFF_W'($urandom), smp);
    endtask

    task automatic send_load(logic [COEFF_IDX_W-1:0] idx, logic signed [COEFF_W-1:0] cval);
        send_word(FUNC_LOAD, idx, cval, 16'($urandom));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.set_reg(idx, val);
        reg_writes++;
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold the sender until every bit has come out and a correlation pass could finish.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (QUIET) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_value(logic [CFG_IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] v;
        longint                energy;
        int                    r;
        r = $urandom_range(0, 9);
        energy = sb.tap_energy(sb.taps_in_use());
        case (idx)
            REG_THRESHOLD:
                case (r)
                    0:       v = '0;
                    1:       v = THRESHOLD_RST;
                    2:       v = '1;
                    3:       v = CFG_DATA_W'({$urandom, $urandom});
                    default: v = CFG_DATA_W'(energy - energy / $urandom_range(2, 8));
                endcase
            REG_PREAMBLE_LEN:
                case (r)
                    0:       v = '0;
                    1:       v = CFG_DATA_W'(255);
                    2:       v = CFG_DATA_W'(128);
                    3:       v = CFG_DATA_W'(1);
                    default: v = CFG_DATA_W'($urandom_range(2, 16));
                endcase
            REG_PACKET_BITS:
                case (r)
                    0:       v = '0;
                    1:       v = CFG_DATA_W'(4095);
                    2:       v = CFG_DATA_W'(1);
                    default: v = CFG_DATA_W'($urandom_range(2, 12));
                endcase
            default:
                case (r)
                    0:       v = '0;
                    1:       v = CFG_DATA_W'(15);
                    2:       v = CFG_DATA_W'(8);
                    3:       v = CFG_DATA_W'(1);
                    default: v = CFG_DATA_W'($urandom_range(2, 8));
                endcase
        endcase
        // Narrow registers must ignore whatever sits above their width.
        if (idx != REG_THRESHOLD && $urandom_range(0, 3) == 0)
            v = v | CFG_DATA_W'({$urandom, $urandom} << 12);
        return v;
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 6))
            0:       return 16'($urandom);
            1:       return 16'sh0000;
            2:       return 16'sh7FFF;
            3:       return 16'sh8000;
            4:       return 16'($urandom_range(0, 2047) - 1024);
            5:       return 16'($urandom_range(1, 32767));
            default: return 16'(32'd0 - $urandom_range(1, 32768));
        endcase
    endfunction

    task automatic run_phase(int n_words);
        int k;
        int pos;
        int len_eff;
        bit mid;
        logic [CFG_IDX_W-1:0] ridx;
        pos = -1;
        mid = ($urandom_range(0, 2) == 0);
        for (k = 0; k < n_words; k++) begin
            // A register change in the middle of a packet, a bit or a hunt.
            if (mid && k == n_words / 2) begin
                settle();
                ridx = CFG_IDX_W'($urandom_range(0, 3));
                write_reg(ridx, '0);
                write_reg(ridx, pick_value(ridx));
                end_writes();
            end
            len_eff = sb.taps_in_use();
            if ($urandom_range(0, 29) == 0)
                send_load(COEFF_IDX_W'($urandom), COEFF_W'($urandom));
            else if (sb.receiving) begin
                pos = -1;
                send_sample(pick_sample());
            end
            else if (pos >= 0 && pos < len_eff) begin
                // Mostly a clean preamble, now and then a corrupted one.
                send_sample(($urandom_range(0, 15) == 0) ? pick_sample() : 16'(sb.taps[pos]));
                pos++;
            end
            else if (len_eff > 0 && $urandom_range(0, 4) == 0) begin
                pos = 1;
                send_sample(16'(sb.taps[0]));
            end
            else begin
                pos = -1;
                send_sample(pick_sample());
            end
        end
    endtask

    initial
    begin
        int k;
        sb = new();
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        func        <= FUNC_SAMPLE;
        coeff_index <= '0;
        coeff_value <= '0;
        sample      <= '0;
        out_stall   <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        idle_on = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Short preamble of full-scale taps, a three-bit packet of two samples per bit.
        write_reg(REG_PREAMBLE_LEN, CFG_DATA_W'(4));
        write_reg(REG_PACKET_BITS, CFG_DATA_W'(3));
        write_reg(REG_SAMPLES_PER_BIT, CFG_DATA_W'(2));
        write_reg(REG_THRESHOLD, CFG_DATA_W'(THRESHOLD_RST));
        end_writes();
        send_load(COEFF_IDX_W'(0), 16'sh7FFF);
        send_load(COEFF_IDX_W'(1), 16'sh8000);
        send_load(COEFF_IDX_W'(2), 16'sh7FFF);
        send_load(COEFF_IDX_W'(3), 16'sh8000);
        send_load(7'd127, 16'shFFFF);
        foreach (DIRECTED_SAMPLES[k])
            send_sample(DIRECTED_SAMPLES[k]);

        // Fill the rest of the tap memory before any longer preamble is used.
        for (k = 4; k < NUM_TAPS; k++)
            send_load(COEFF_IDX_W'(k), (k % 9 == 0) ? 16'sh8000 : COEFF_W'($urandom));

        while (words_sent < ITEMS) begin
            settle();
            write_reg(REG_PREAMBLE_LEN, pick_value(REG_PREAMBLE_LEN));
            write_reg(REG_PACKET_BITS, pick_value(REG_PACKET_BITS));
            write_reg(REG_SAMPLES_PER_BIT, pick_value(REG_SAMPLES_PER_BIT));
            write_reg(REG_THRESHOLD, pick_value(REG_THRESHOLD));
            end_writes();
            idle_on = (words_sent < ITEMS * 4 / 5) && ($urandom_range(0, 3) != 0);
            run_phase($urandom_range(40, 120));
        end
        settle();

        $display("Sent %0d input words under %0d register writes; %0d preambles detected.",
                 words_sent, reg_writes, sb.detections);
        $display("Checked %0d demodulated bit words, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
